// ===== rtl/dcba_pkg.sv =====
`timescale 1ns / 1ps

package dcba_pkg;

  localparam int CHANNELS         = 8;
  localparam int CH_W             = 3;
  localparam int DEF_BUFFER_BYTES = 262144;
  localparam int DEF_TASK_ID_BITS = 8;
  localparam int ADDR_W           = 24;
  localparam int LEN_W            = 19;
  localparam int TASK_W           = 8;
  localparam int TAG_W            = 8;
  localparam int TMODE_W          = 8;
  localparam int ALIGN_W          = 17;

  localparam logic [ADDR_W-1:0]  PHYS_BASE_RESET  = 24'h010000;
  localparam logic [ALIGN_W-1:0] ALIGN_SMALL_MASK = 17'h0FFFF;
  localparam logic [ALIGN_W-1:0] ALIGN_BIG_MASK   = 17'h1FFFF;

  localparam logic [CH_W-1:0] CH_RESERVED_LO = 3'd0;
  localparam logic [CH_W-1:0] CH_RESERVED_HI = 3'd4;
  localparam logic [CH_W-1:0] CH_BIG_FIRST   = 3'd5;

  typedef enum logic [1:0] {
    MODE_GET,
    MODE_SET,
    MODE_FREE,
    MODE_UNKNOWN
  } mode_t;

  typedef enum logic [1:0] {
    RES_OK,
    RES_FAIL,
    RES_ALLOC_FAIL,
    RES_TAKEN
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WALK,
    ST_GAP,
    ST_FIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [CH_W-1:0]    dma_channel;
    logic [TASK_W-1:0]  task_id;
    logic [LEN_W-1:0]   buffer_size;
    logic [TMODE_W-1:0] transfer_mode;
    logic [TAG_W-1:0]   thread_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         op_echo;
    logic [1:0]         result_code;
    logic [TAG_W-1:0]   reply_tag;
    logic               program_dma;
    logic [CH_W-1:0]    program_channel;
    logic [ADDR_W-1:0]  phys_address;
    logic [LEN_W-1:0]   program_length;
    logic [TMODE_W-1:0] program_mode;
  } out_item_t;

endpackage

// ===== rtl/dma_channel_buffer_allocator_unit.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// in        input      in_valid/in_stall    in_data (in_item_t)
// out       output     out_valid/out_stall  out_data (out_item_t)
// cfg       input      cfg_wr_en            cfg_wr_data (phys_base)
//
// a transaction that needs no placement goes through LOOKUP and DONE only
// a placement visits g gaps (1..6) in WALK, GAP, FIT, one shared gap-fit unit
// each gap visit is a channel table read, a gap/pad step and a fit compare
// rst_n is synchronous: all channels free, phys_base back to 0x10000
// in_stall is high from accept until the result is loaded; a stalled result does
// not block the next accept, only the handoff of the following result

module dma_channel_buffer_allocator_unit
  import dcba_pkg::*;
#(
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
  parameter int TASK_ID_BITS = DEF_TASK_ID_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [ADDR_W-1:0] cfg_wr_data
);

  localparam int OFF_W = $clog2(BUFFER_BYTES + 1);
  localparam int CMP_W = ((OFF_W > LEN_W) ? OFF_W : LEN_W) + 1;
  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam logic [OFF_W-1:0] BUF_END = OFF_W'(BUFFER_BYTES);

  typedef struct packed {
    logic [TASK_ID_BITS-1:0] owner;
    logic [OFF_W-1:0]        offset;
    logic [LEN_W-1:0]        length;
  } entry_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   phys_base_r, phys_base_nxt;
  in_item_t            req_r, req_nxt;
  logic [CHANNELS-1:0] owned_r, owned_nxt;
  logic [CH_W-1:0]     order_r   [CHANNELS];
  logic [CH_W-1:0]     order_nxt [CHANNELS];
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [OFF_W-1:0]    gs_r, gs_nxt;
  logic [OFF_W-1:0]    av_r, av_nxt;
  logic [ALIGN_W-1:0]  pad_r, pad_nxt;
  result_t             res_code_r, res_code_nxt;
  logic                res_prog_r, res_prog_nxt;
  logic [OFF_W-1:0]    res_off_r, res_off_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  entry_t              chan_mem [CHANNELS];
  entry_t              mem_rd_r;
  logic                mem_we, mem_re;
  logic [CH_W-1:0]     mem_waddr, mem_raddr;
  entry_t              mem_wdata;

  logic [TASK_ID_BITS-1:0] req_task;
  logic [CH_W-1:0]     ch;
  logic [ALIGN_W-1:0]  align_mask;
  logic [OFF_W-1:0]    gap_end;
  logic [ALIGN_W-1:0]  p_low;
  logic [ALIGN_W-1:0]  pad;
  logic [OFF_W-1:0]    av;
  logic [CMP_W-1:0]    av_x, pad_x, size_x;
  logic                fit;
  logic [OFF_W-1:0]    new_off;
  logic [OFF_W-1:0]    gs_walk;
  logic [CH_W-1:0]     order_rm  [CHANNELS];
  logic [CH_W-1:0]     order_ins [CHANNELS];
  logic                seen;

  generate
    if (TASK_ID_BITS <= TASK_W) begin : g_tid_trunc
      assign req_task = req_r.task_id[TASK_ID_BITS-1:0];
    end else begin : g_tid_ext
      assign req_task = {{(TASK_ID_BITS - TASK_W){1'b0}}, req_r.task_id};
    end
  endgenerate

  assign ch         = req_r.dma_channel;
  assign align_mask = (ch >= CH_BIG_FIRST) ? ALIGN_BIG_MASK : ALIGN_SMALL_MASK;

  // shared gap-fit unit
  assign gap_end = (idx_r < count_r) ? mem_rd_r.offset : BUF_END;
  assign p_low   = phys_base_r[ALIGN_W-1:0] + gs_r[ALIGN_W-1:0];
  assign pad     = (ALIGN_W'(0) - p_low) & align_mask;
  assign av      = (gap_end > gs_r) ? (gap_end - gs_r) : '0;
  assign av_x    = CMP_W'(av_r);
  assign pad_x   = CMP_W'(pad_r);
  assign size_x  = CMP_W'(req_r.buffer_size);
  assign fit     = (size_x < av_x) && (av_x > pad_x) && ((av_x - pad_x) >= size_x);
  assign new_off = gs_r + OFF_W'(pad_r);
  assign gs_walk = OFF_W'(CMP_W'(mem_rd_r.offset) + CMP_W'(mem_rd_r.length));

  // address-ordered list: remove ch, or insert ch at idx
  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < CHANNELS; j++) begin
      seen = seen | ((CNT_W'(j) < count_r) && (order_r[j] == ch));
      order_rm[j] = order_r[j];
      if (seen && (j < CHANNELS - 1)) begin
        order_rm[j] = order_r[j+1];
      end
      order_ins[j] = order_r[j];
      if (CNT_W'(j) == idx_r) begin
        order_ins[j] = ch;
      end else if ((j > 0) && (CNT_W'(j) > idx_r)) begin
        order_ins[j] = order_r[j-1];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phys_base_nxt = phys_base_r;
    req_nxt       = req_r;
    owned_nxt     = owned_r;
    order_nxt     = order_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    gs_nxt        = gs_r;
    av_nxt        = av_r;
    pad_nxt       = pad_r;
    res_code_nxt  = res_code_r;
    res_prog_nxt  = res_prog_r;
    res_off_nxt   = res_off_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = ch;
    mem_wdata     = '{owner: req_task, offset: new_off, length: req_r.buffer_size};
    mem_re        = 1'b0;
    mem_raddr     = ch;

    if (cfg_wr_en) begin
      phys_base_nxt = cfg_wr_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          mem_re    = 1'b1;
          mem_raddr = in_data.dma_channel;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        res_code_nxt = RES_FAIL;
        res_prog_nxt = 1'b0;
        res_off_nxt  = mem_rd_r.offset;
        state_nxt    = ST_DONE;
        if ((ch != CH_RESERVED_LO) && (ch != CH_RESERVED_HI)) begin
          case (mode_t'(req_r.mode))
            MODE_GET: begin
              if (owned_r[ch]) begin
                res_code_nxt = RES_TAKEN;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            MODE_SET: begin
              if (!owned_r[ch] || (mem_rd_r.owner == req_task)) begin
                if (owned_r[ch] && (mem_rd_r.length == req_r.buffer_size)) begin
                  res_code_nxt = RES_OK;
                  res_prog_nxt = 1'b1;
                end else begin
                  if (owned_r[ch]) begin
                    owned_nxt[ch] = 1'b0;
                    order_nxt     = order_rm;
                    count_nxt     = count_r - CNT_W'(1);
                  end
                  state_nxt = ST_WALK;
                end
              end
            end
            MODE_FREE: begin
              if (owned_r[ch] && (mem_rd_r.owner == req_task)) begin
                owned_nxt[ch] = 1'b0;
                order_nxt     = order_rm;
                count_nxt     = count_r - CNT_W'(1);
                res_code_nxt  = RES_OK;
              end
            end
            default: ;
          endcase
        end
        idx_nxt = '0;
        gs_nxt  = '0;
      end
      ST_WALK: begin
        mem_re    = 1'b1;
        mem_raddr = order_r[idx_r[CH_W-1:0]];
        state_nxt = ST_GAP;
      end
      ST_GAP: begin
        av_nxt    = av;
        pad_nxt   = pad;
        state_nxt = ST_FIT;
      end
      ST_FIT: begin
        if (fit) begin
          mem_we        = 1'b1;
          owned_nxt[ch] = 1'b1;
          order_nxt     = order_ins;
          count_nxt     = count_r + CNT_W'(1);
          res_code_nxt  = RES_OK;
          res_prog_nxt  = 1'b1;
          res_off_nxt   = new_off;
          state_nxt     = ST_DONE;
        end else if (idx_r < count_r) begin
          gs_nxt    = gs_walk;
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = ST_WALK;
        end else begin
          res_code_nxt = RES_ALLOC_FAIL;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.op_echo         = req_r.mode;
          out_data_nxt.result_code     = res_code_r;
          out_data_nxt.reply_tag       = req_r.thread_tag;
          out_data_nxt.program_dma     = res_prog_r;
          out_data_nxt.program_channel = res_prog_r ? ch : '0;
          out_data_nxt.phys_address    = res_prog_r ?
                                         (phys_base_r + ADDR_W'(res_off_r)) : '0;
          out_data_nxt.program_length  = res_prog_r ? req_r.buffer_size : '0;
          out_data_nxt.program_mode    = res_prog_r ? req_r.transfer_mode : '0;
          state_nxt                    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phys_base_r <= PHYS_BASE_RESET;
      owned_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < CHANNELS; j++) begin
        order_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      phys_base_r <= phys_base_nxt;
      owned_r     <= owned_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      order_r     <= order_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    gs_r       <= gs_nxt;
    av_r       <= av_nxt;
    pad_r      <= pad_nxt;
    res_code_r <= res_code_nxt;
    res_prog_r <= res_prog_nxt;
    res_off_r  <= res_off_nxt;
    out_data_r <= out_data_nxt;
  end

  // channel table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      chan_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_r <= chan_mem[mem_raddr];
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/dcba_checker.sv =====
`timescale 1ns / 1ps

module dcba_checker
  import dcba_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a second transaction while busy");

  a_no_prog_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.program_dma |->
      out_data.program_channel == '0 && out_data.phys_address == '0 &&
      out_data.program_length == '0 && out_data.program_mode == '0)
    else $error("program fields set without program_dma");

  a_prog_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.program_dma |->
      out_data.result_code == RES_OK &&
      (out_data.op_echo == MODE_GET || out_data.op_echo == MODE_SET))
    else $error("program_dma on a failed or non-placing transaction");

  a_taken_get: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_code == RES_TAKEN |-> out_data.op_echo == MODE_GET)
    else $error("channel taken reported for a non-get transaction");

endmodule

bind dma_channel_buffer_allocator_unit dcba_checker u_dcba_checker (.*);
